// ===== design/gtsc_pkg.sv =====
// Shared types, constants and the logarithm table of the competition simulator.
package gtsc_pkg;

    localparam int W_DVD = 52;           // divider dividend and quotient width
    localparam int W_DVS = 38;           // divider divisor width
    localparam int W_CNT = 6;            // divider step counter width

    localparam logic [26:0] RATE_GOOD   = 27'd107374182;   // 0.1 in Q2.30
    localparam logic [26:0] RATE_BAD    = 27'd53687091;    // 0.05 in Q2.30
    localparam logic [31:0] TIME_LIMIT  = 32'd983040000;   // 15000 in Q16.16
    localparam logic [31:0] TIME_ENDED  = 32'd983046554;   // 15000.1 in Q16.16
    localparam logic [15:0] START_POP   = 16'd500;
    localparam logic [15:0] LN2_Q16     = 16'd45426;
    localparam logic [31:0] SEASON_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] SEASON_MIN  = 32'h8000_0001;   // -SEASON_MAX

    // configuration register indexes
    localparam logic [2:0] REG_GOOD_CHANCE = 3'd0;
    localparam logic [2:0] REG_GOOD_LEN    = 3'd1;
    localparam logic [2:0] REG_BAD_LEN     = 3'd2;
    localparam logic [2:0] REG_RANDOM      = 3'd3;
    localparam logic [2:0] REG_CAP_SG      = 3'd4;
    localparam logic [2:0] REG_CAP_GG      = 3'd5;
    localparam logic [2:0] REG_CAP_SB      = 3'd6;
    localparam logic [2:0] REG_CAP_GB      = 3'd7;

    // season kinds
    localparam logic [1:0] SK_NONE = 2'd0;
    localparam logic [1:0] SK_GOOD = 2'd1;
    localparam logic [1:0] SK_BAD  = 2'd2;

    // event kinds
    localparam logic [2:0] EV_SPEC_BIRTH = 3'd0;
    localparam logic [2:0] EV_GEN_BIRTH  = 3'd1;
    localparam logic [2:0] EV_SPEC_DEATH = 3'd2;
    localparam logic [2:0] EV_GEN_DEATH  = 3'd3;
    localparam logic [2:0] EV_NONE       = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEASON,
        OP_PARAM,
        OP_DIVS,
        OP_SAVES,
        OP_DIVG,
        OP_SAVEG,
        OP_LOG1,
        OP_LOG2,
        OP_DIVT,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic ended;
        logic div_busy;
        logic out_full;
    } t_stat;

    typedef struct packed {
        logic        spec_extinct;
        logic        gen_extinct;
        logic        time_up;
        logic [2:0]  event_kind;
        logic        season_bad;
        logic [31:0] elapsed;
        logic [15:0] gen_count;
        logic [15:0] spec_count;
    } t_result;

    // ln(1 + i/16) in Q0.16
    function automatic logic [15:0] ln_tab(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41197;
            5'd15:   v = 16'd43345;
            5'd16:   v = 16'd45426;
            default: v = 16'd45426;
        endcase
        return v;
    endfunction

endpackage

// ===== design/gillespie_two_species_competition.sv =====
// Top level of the two-species stochastic competition simulator.
//
// Usage: each input beat on the s_axis channel carries one command (tuser)
// and three Q0.32 uniform fractions (tdata). A simulate command advances the
// replicate by one birth or death event and the matching time step; a restart
// command puts both populations back to 500 and time to zero. Every beat gives
// exactly one result beat on m_axis with both counts, elapsed time, season,
// the event taken and the end-of-run flags.
// A simulate step makes three passes through the shared radix-2 divider (two
// death propensities and the time advance); a restart or a step after the run
// ended skips them. One item is in flight at a time; s_axis_tready is high
// only while the controller is idle, also while a result still waits.
// Reset (synchronous, active low) loads the default configuration, sets the
// counts to 500, time and season to zero and empties the result register.
// When the receiver stalls, the result holds in the output register and the
// next finished step waits until that beat is taken.
// Configuration is written through i_cfg_we/i_cfg_addr/i_cfg_data; write only
// while the block is idle.
module gillespie_two_species_competition import gtsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // u_season[31:0], u_time[63:32], u_event[95:64]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // spec_count[15:0], gen_count[31:16], elapsed[63:32], season_bad[64],
    // event_kind[67:65], time_up[68], gen_extinct[69], spec_extinct[70], zero[71]
    output logic [71:0] m_axis_tdata
);

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_result;

    gtsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gtsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_cmd    (s_axis_tuser),
        .i_u_season  (s_axis_tdata[31:0]),
        .i_u_time    (s_axis_tdata[63:32]),
        .i_u_event   (s_axis_tdata[95:64]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result)
    );

    // pack the result beat, last struct field lowest, a zero bit on top
    assign m_axis_tdata = {1'b0, w_result};

endmodule

// ===== design/gtsc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module gtsc_div import gtsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [W_DVD-1:0]   i_dividend,
    input  logic [W_DVS-1:0]   i_divisor,
    output logic               o_busy,
    output logic [W_DVD-1:0]   o_quo
);

    logic [W_DVS-1:0] r_rem;
    logic [W_DVS-1:0] r_dvs;
    logic [W_DVD-1:0] r_quo;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic [W_DVS:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[W_DVD-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= W_CNT'(W_DVD);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == W_CNT'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // capture both operands at start so the operand mux is free while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? W_DVS'(w_trial - {1'b0, r_dvs}) : w_trial[W_DVS-1:0];
            r_quo <= {r_quo[W_DVD-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== design/gtsc_dp.sv =====
// Datapath: configuration, simulation state, propensities, log and result register.
module gtsc_dp import gtsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_in_cmd,
    input  logic [31:0] i_u_season,
    input  logic [31:0] i_u_time,
    input  logic [31:0] i_u_event,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_result     o_result
);

    // configuration
    logic [15:0] r_chance, r_good_len, r_bad_len;
    logic        r_random;
    logic [23:0] r_cap_sg, r_cap_gg, r_cap_sb, r_cap_gb;

    // simulation state
    logic [15:0] r_spec, r_gen;
    logic [31:0] r_sim, r_left;
    logic [1:0]  r_kind;

    // latched item
    logic        r_cmd;
    logic [31:0] r_u_season, r_u_event;

    // working registers
    logic [31:0] r_f;
    logic [4:0]  r_p;
    logic [23:0] r_cs, r_cg;
    logic [43:0] r_rn;
    logic [33:0] r_c1, r_c2, r_c3, r_total;
    logic [37:0] r_tot10;
    logic [31:0] r_lprod;
    logic [15:0] r_lbase;
    logic [21:0] r_base, r_neglog;
    logic [63:0] r_tlo;
    logic [33:0] r_thi;
    logic [34:0] r_target;

    logic        r_out_valid;
    t_result     r_result;

    // divider hookup
    logic             w_div_start;
    logic [W_DVD-1:0] w_dividend;
    logic [W_DVS-1:0] w_divisor;
    logic             w_div_busy;
    logic [W_DVD-1:0] w_quo;
    logic [31:0]      w_quo_sat;

    gtsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo)
    );

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = {r_rn, 8'h00};
        w_divisor   = {14'h0, r_cs};
        case (i_cmd.op)
            OP_DIVS: begin
                w_div_start = 1'b1;
            end
            OP_DIVG: begin
                w_div_start = 1'b1;
                w_divisor   = {14'h0, r_cg};
            end
            OP_DIVT: begin
                w_div_start = 1'b1;
                w_dividend  = {r_neglog, 30'h0};
                w_divisor   = r_tot10;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    assign w_quo_sat = (|w_quo[W_DVD-1:32]) ? 32'hFFFF_FFFF : w_quo[31:0];

    // new season
    logic        w_rand_good, w_alt_good, w_new_good;
    logic [17:0] w_mop;
    logic [33:0] w_prod, w_raw;
    logic [31:0] w_len;

    assign w_rand_good = (r_u_season < {r_chance, 16'h0});
    assign w_alt_good  = (r_kind == SK_NONE) || (r_kind == SK_BAD);
    assign w_mop       = w_alt_good ? {1'b0, r_chance, 1'b0}
                                    : 18'(18'd131072 - {1'b0, r_chance, 1'b0});
    assign w_prod      = r_good_len * w_mop;
    assign w_new_good  = r_random ? w_rand_good : w_alt_good;
    assign w_raw       = r_random ? {2'b00, (w_rand_good ? r_good_len : r_bad_len), 16'h0}
                                  : w_prod;
    assign w_len       = (w_raw > {2'b00, SEASON_MAX}) ? SEASON_MAX : w_raw[31:0];

    // parameters of the current season
    logic        w_bad;
    logic [26:0] w_rate;
    logic [23:0] w_cs, w_cg;
    logic [16:0] w_n;

    assign w_bad  = (r_kind == SK_BAD);
    assign w_rate = w_bad ? RATE_BAD : RATE_GOOD;
    assign w_cs   = w_bad ? r_cap_sb : r_cap_sg;
    assign w_cg   = w_bad ? r_cap_gb : r_cap_gg;
    assign w_n    = {1'b0, r_spec} + {1'b0, r_gen};

    // log interpolation
    logic [3:0]  w_idx;
    logic [15:0] w_diff;

    assign w_idx  = r_f[30:27];
    assign w_diff = ln_tab({1'b0, w_idx} + 5'd1) - ln_tab({1'b0, w_idx});

    // event and time update
    logic [15:0] w_spec, w_gen;
    logic [2:0]  w_ev;
    logic [31:0] w_sim;
    logic        w_up;
    logic [53:0] w_ldiff;
    logic [31:0] w_left;

    always_comb begin
        w_spec = r_spec;
        w_gen  = r_gen;
        w_ev   = EV_NONE;
        if ((r_target < {1'b0, r_c1}) && (r_spec != 16'h0)) begin
            w_ev = EV_SPEC_BIRTH;
            if (r_spec != 16'hFFFF) w_spec = r_spec + 16'd1;
        end else if ((r_target < {1'b0, r_c2}) && (r_gen != 16'h0)) begin
            w_ev = EV_GEN_BIRTH;
            if (r_gen != 16'hFFFF) w_gen = r_gen + 16'd1;
        end else if ((r_target < {1'b0, r_c3}) && (r_spec != 16'h0)) begin
            w_ev   = EV_SPEC_DEATH;
            w_spec = r_spec - 16'd1;
        end else if (r_gen != 16'h0) begin
            w_ev  = EV_GEN_DEATH;
            w_gen = r_gen - 16'd1;
        end
    end

    assign w_sim   = r_sim + w_quo[31:0];
    assign w_up    = (w_sim >= TIME_LIMIT);
    assign w_ldiff = {{22{r_left[31]}}, r_left} - {2'b00, w_quo};
    assign w_left  = ($signed(w_ldiff) < $signed({{22{1'b1}}, SEASON_MIN})) ? SEASON_MIN
                                                                          : w_ldiff[31:0];

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chance   <= 16'd45875;
            r_good_len <= 16'd200;
            r_bad_len  <= 16'd200;
            r_random   <= 1'b1;
            r_cap_sg   <= 24'd217600;
            r_cap_gg   <= 24'd151076;
            r_cap_sb   <= 24'd32000;
            r_cap_gb   <= 24'd38400;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GOOD_CHANCE: r_chance   <= i_cfg_data[15:0];
                REG_GOOD_LEN:    r_good_len <= i_cfg_data[15:0];
                REG_BAD_LEN:     r_bad_len  <= i_cfg_data[15:0];
                REG_RANDOM:      r_random   <= i_cfg_data[0];
                REG_CAP_SG:      r_cap_sg   <= i_cfg_data;
                REG_CAP_GG:      r_cap_gg   <= i_cfg_data;
                REG_CAP_SB:      r_cap_sb   <= i_cfg_data;
                REG_CAP_GB:      r_cap_gb   <= i_cfg_data;
                default:         r_random   <= r_random;
            endcase
        end
    end

    // simulation state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec      <= START_POP;
            r_gen       <= START_POP;
            r_sim       <= '0;
            r_left      <= '0;
            r_kind      <= SK_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (i_cmd.op != OP_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_SEASON: begin
                    if ($signed(r_left) <= 0) begin
                        r_kind <= w_new_good ? SK_GOOD : SK_BAD;
                        r_left <= w_len;
                    end
                end
                OP_FINISH: begin
                    r_out_valid          <= 1'b1;
                    r_result.season_bad  <= w_bad;
                    if (r_cmd) begin
                        r_spec <= START_POP;
                        r_gen  <= START_POP;
                        r_sim  <= '0;
                        r_left <= '0;
                        r_result.spec_count   <= START_POP;
                        r_result.gen_count    <= START_POP;
                        r_result.elapsed      <= '0;
                        r_result.event_kind   <= EV_NONE;
                        r_result.time_up      <= 1'b0;
                        r_result.gen_extinct  <= 1'b0;
                        r_result.spec_extinct <= 1'b0;
                    end else if (r_sim >= TIME_LIMIT) begin
                        r_result.spec_count   <= r_spec;
                        r_result.gen_count    <= r_gen;
                        r_result.elapsed      <= r_sim;
                        r_result.event_kind   <= EV_NONE;
                        r_result.time_up      <= 1'b1;
                        r_result.gen_extinct  <= (r_gen == 16'h0);
                        r_result.spec_extinct <= (r_spec == 16'h0);
                    end else begin
                        r_spec <= w_spec;
                        r_gen  <= w_gen;
                        r_left <= w_left;
                        r_sim  <= ((w_spec == 16'h0) || (w_gen == 16'h0)) ? TIME_ENDED : w_sim;
                        r_result.spec_count   <= w_spec;
                        r_result.gen_count    <= w_gen;
                        r_result.elapsed      <= ((w_spec == 16'h0) || (w_gen == 16'h0))
                                                 ? TIME_ENDED : w_sim;
                        r_result.event_kind   <= w_ev;
                        r_result.time_up      <= w_up;
                        r_result.gen_extinct  <= (w_gen == 16'h0);
                        r_result.spec_extinct <= (w_spec == 16'h0);
                    end
                end
                default: begin
                    r_kind <= r_kind;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd      <= i_in_cmd;
                r_u_season <= i_u_season;
                r_u_event  <= i_u_event;
                r_f        <= (i_u_time == 32'h0) ? 32'h1 : i_u_time;
                r_p        <= 5'd31;
            end
            OP_PARAM: begin
                r_cs <= (w_cs == 24'h0) ? 24'h1 : w_cs;
                r_cg <= (w_cg == 24'h0) ? 24'h1 : w_cg;
                r_rn <= w_rate * w_n;
                r_c1 <= {7'h0, w_rate};
                r_c2 <= {7'h0, w_rate} + ((r_gen != 16'h0) ? {7'h0, w_rate} : 34'h0);
            end
            OP_SAVES: begin
                r_c3 <= r_c2 + {2'b00, w_quo_sat};
            end
            OP_SAVEG: begin
                r_total <= r_c3 + {2'b00, w_quo_sat};
            end
            OP_LOG1: begin
                r_lprod <= w_diff * r_f[26:11];
                r_lbase <= ln_tab({1'b0, w_idx});
                r_base  <= (6'd32 - {1'b0, r_p}) * LN2_Q16;
                r_tot10 <= {1'b0, r_total, 3'h0} + {3'h0, r_total, 1'b0};
                r_tlo   <= r_u_event * r_total[31:0];
                r_thi   <= r_u_event * r_total[33:32];
            end
            OP_LOG2: begin
                r_neglog <= r_base - ({6'h0, r_lbase} + {6'h0, r_lprod[31:16]});
                r_target <= {1'b0, r_thi} + {3'h0, r_tlo[63:32]};
            end
            default: begin
                // normalize u_time: shift until the top bit is set
                if (!r_f[31]) begin
                    r_f <= {r_f[30:0], 1'b0};
                    r_p <= r_p - 5'd1;
                end
            end
        endcase
    end

    assign o_stat.restart  = r_cmd;
    assign o_stat.ended    = (r_sim >= TIME_LIMIT);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_full = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ===== design/gtsc_ctrl.sv =====
// Controller: sequences one simulation step through the datapath.
module gtsc_ctrl import gtsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEASON,
        ST_PARAM,
        ST_DIVS,
        ST_WAITS,
        ST_SAVES,
        ST_DIVG,
        ST_WAITG,
        ST_SAVEG,
        ST_LOG1,
        ST_LOG2,
        ST_DIVT,
        ST_WAITT,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    t_op    w_op;

    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (i_stat.restart || i_stat.ended) ? ST_FINISH : ST_SEASON;
            end
            ST_SEASON: begin
                w_op    = OP_SEASON;
                n_state = ST_PARAM;
            end
            ST_PARAM: begin
                w_op    = OP_PARAM;
                n_state = ST_DIVS;
            end
            ST_DIVS: begin
                w_op    = OP_DIVS;
                n_state = ST_WAITS;
            end
            ST_WAITS: begin
                if (!i_stat.div_busy) n_state = ST_SAVES;
            end
            ST_SAVES: begin
                w_op    = OP_SAVES;
                n_state = ST_DIVG;
            end
            ST_DIVG: begin
                w_op    = OP_DIVG;
                n_state = ST_WAITG;
            end
            ST_WAITG: begin
                if (!i_stat.div_busy) n_state = ST_SAVEG;
            end
            ST_SAVEG: begin
                w_op    = OP_SAVEG;
                n_state = ST_LOG1;
            end
            ST_LOG1: begin
                w_op    = OP_LOG1;
                n_state = ST_LOG2;
            end
            ST_LOG2: begin
                w_op    = OP_LOG2;
                n_state = ST_DIVT;
            end
            ST_DIVT: begin
                w_op    = OP_DIVT;
                n_state = ST_WAITT;
            end
            ST_WAITT: begin
                if (!i_stat.div_busy) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!i_stat.out_full) begin
                    w_op    = OP_FINISH;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.op   = w_op;

endmodule
